// ----- hw/rtl/dq_pkg.sv -----
// shared types and codes for the double-ended queue
package dq_pkg;

   localparam int VALUE_W = 32;

   // action codes
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd1;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_LIST_FWD   = 3'd4;
   localparam logic [2:0] ACT_LIST_BWD   = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]                action;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       list_start;
      logic       list_fwd;
      logic       list_next;
      logic       emit_status;
      logic       emit_data;
      logic [1:0] status;
   } dq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
      logic empty;
      logic full;
      logic list_last;
   } dq_stat_type;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// top level of the bounded double-ended queue
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   dq_pkg::req_type (action, value)
//   rsp      out        rsp_valid/rsp_stall   dq_pkg::rsp_type (value_res, status, last)
//
// a push or pop loads one word into the output register
// a listing of n values starts with one ram read, then gives one word per cycle while the output can move;
// the read ahead is set by the single registered read port of the slot ram
// reset clears the front pointer, the count and the output valid bit; slots need no clear
// req_stall is high during a listing and while a stalled output word cannot move
module double_ended_queue #(
   parameter int DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);

   dq_pkg::dq_cmd_type  cmd;
   dq_pkg::dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   dq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/dq_ram.sv -----
// generic single-write, single-read ram with registered read
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dq_dp.sv -----
// datapath: ring pointers, slot ram, listing walker and output register
module dq_dp #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dq_pkg::dq_cmd_type  cmd,
   output dq_pkg::dq_stat_type stat,
   input  dq_pkg::req_type     req_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output dq_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             fwd_ff, fwd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dq_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]          front_dec, tail_pos, back_pos, start_pos, ptr_step;
   logic                      wr_en, rd_en;
   logic [IDX_W-1:0]          wr_addr, rd_addr;
   logic [dq_pkg::VALUE_W-1:0] rd_data;

   function automatic logic [IDX_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
      if (s >= SUM_W'(DEPTH)) begin
         return IDX_W'(s - SUM_W'(DEPTH));
      end
      return IDX_W'(s);
   endfunction

   function automatic logic [IDX_W-1:0] inc_pos(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(p + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] dec_pos(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(p - 1'b1);
   endfunction

   assign front_dec = dec_pos(front_ff);
   assign tail_pos  = wrap_pos(SUM_W'(front_ff) + SUM_W'(count_ff));
   // only used while count is nonzero
   assign back_pos  = wrap_pos(SUM_W'(front_ff) + SUM_W'(count_ff) - SUM_W'(1));
   assign start_pos = cmd.list_fwd ? front_ff : back_pos;
   assign ptr_step  = fwd_ff ? inc_pos(ptr_ff) : dec_pos(ptr_ff);

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = tail_pos;
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.push_front) begin
         wr_en    = 1'b1;
         wr_addr  = front_dec;
         front_in = front_dec;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.push_back) begin
         wr_en    = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop_front) begin
         front_in = inc_pos(front_ff);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // listing walker: read issued ahead of the output load
   assign rd_en   = cmd.list_start | cmd.list_next;
   assign rd_addr = cmd.list_start ? start_pos : ptr_step;

   always_comb begin
      ptr_in = ptr_ff;
      rem_in = rem_ff;
      fwd_in = fwd_ff;
      if (cmd.list_start) begin
         ptr_in = start_pos;
         rem_in = IDX_W'(count_ff - CNT_W'(1));
         fwd_in = cmd.list_fwd;
      end else if (cmd.list_next) begin
         ptr_in = ptr_step;
         rem_in = rem_ff - IDX_W'(1);
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.emit_status) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_res = '0;
         rsp_data_in.status    = cmd.status;
         rsp_data_in.last      = 1'b1;
      end else if (cmd.emit_data) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_res = rd_data;
         rsp_data_in.status    = dq_pkg::STAT_OK;
         rsp_data_in.last      = (rem_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      fwd_ff      <= fwd_in;
      rsp_data_ff <= rsp_data_in;
   end

   dq_ram #(
      .WIDTH (dq_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.list_last = (rem_ff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
// controller: decodes actions and sequences listings
module dq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_action,
   output logic                req_stall,
   input  dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic state_ff, state_in;
   logic accept;

   assign req_stall = (state_ff != S_IDLE) | ~stat.rsp_free;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      cmd      = '0;
      cmd.status = dq_pkg::STAT_OK;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
                     cmd.emit_status = 1'b1;
                     if (stat.full) begin
                        cmd.status = dq_pkg::STAT_FULL;
                     end else begin
                        cmd.push_front = (req_action == dq_pkg::ACT_PUSH_FRONT);
                        cmd.push_back  = (req_action == dq_pkg::ACT_PUSH_BACK);
                     end
                  end
                  dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
                     cmd.emit_status = 1'b1;
                     if (stat.empty) begin
                        cmd.status = dq_pkg::STAT_EMPTY;
                     end else begin
                        cmd.pop_front = (req_action == dq_pkg::ACT_POP_FRONT);
                        cmd.pop_back  = (req_action == dq_pkg::ACT_POP_BACK);
                     end
                  end
                  dq_pkg::ACT_LIST_FWD, dq_pkg::ACT_LIST_BWD: begin
                     if (stat.empty) begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = dq_pkg::STAT_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                        cmd.list_fwd   = (req_action == dq_pkg::ACT_LIST_FWD);
                        state_in       = S_LIST;
                     end
                  end
                  default: begin
                     // unused codes are dropped
                  end
               endcase
            end
         end
         S_LIST: begin
            if (stat.rsp_free) begin
               cmd.emit_data = 1'b1;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.list_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
